/* hw/rtl/wps_pkg.sv */
// Shared constants, types and register codes of the windowed peak smoother.
package wps_pkg;

  // Frame and sample geometry
  localparam int unsigned MaxBins  = 512;
  localparam int unsigned BinW     = $clog2(MaxBins);
  localparam int unsigned CntW     = BinW + 1;
  localparam int unsigned MaxPrec  = 10;
  localparam int unsigned WinDepth = MaxPrec + 1;
  localparam int unsigned AgeW     = $clog2(WinDepth);
  localparam int unsigned RadW     = $clog2(MaxPrec / 2 + 1);
  localparam int unsigned SampleW  = 16;

  // Register field widths
  localparam int unsigned FrameW = 10;
  localparam int unsigned QW     = 16;
  localparam int unsigned PrecW  = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Q1.15 weight
  localparam int unsigned QFrac = 15;
  localparam logic [QW-1:0] QOne = QW'(32768);

  // Reset values of the registers
  localparam logic [FrameW-1:0] FrameSizeRst = FrameW'(512);
  localparam logic [QW-1:0]     QuantityRst  = QW'(16384);
  localparam logic [PrecW-1:0]  PrecisionRst = '0;

  typedef logic signed [SampleW-1:0] sample_t;

  localparam sample_t SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleW-1){1'b0}}};

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameSize = 2'd0,
    CfgQuantity  = 2'd1,
    CfgPrecision = 2'd2
  } cfg_idx_e;

  // Control of the lookahead window
  typedef struct packed {
    logic            shift;     // take the incoming sample in
    logic            incl_new;  // incoming sample counts as the newest entry
    logic [AgeW-1:0] amax;      // oldest entry that counts, by age
  } win_ctrl_t;

endpackage

/* hw/rtl/wps_window.sv */
// Lookahead shift line of recent samples and the masked maximum over it.
module wps_window (
  input  logic               clk_i,
  input  wps_pkg::win_ctrl_t ctrl_i,
  input  wps_pkg::sample_t   sample_i,
  output wps_pkg::sample_t   max_o
);
  import wps_pkg::*;

  localparam int unsigned TreeN = 16;

  sample_t win_q [WinDepth];
  sample_t cand  [WinDepth];
  sample_t lvl0  [TreeN];
  sample_t lvl1  [TreeN/2];
  sample_t lvl2  [TreeN/4];
  sample_t lvl3  [TreeN/8];

  function automatic sample_t smax(sample_t a, sample_t b);
    return (a > b) ? a : b;
  endfunction

  // Shift the new sample in, newest at entry zero
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      win_q[0] <= sample_i;
      for (int i = 1; i < WinDepth; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  // Order candidates by age; the incoming sample is age zero when it counts
  always_comb begin
    cand[0] = ctrl_i.incl_new ? sample_i : win_q[0];
    for (int i = 1; i < WinDepth; i++) begin
      cand[i] = ctrl_i.incl_new ? win_q[i-1] : win_q[i];
    end
  end

  // Mask ages beyond the window, then reduce by a pairwise tree
  always_comb begin
    for (int i = 0; i < TreeN; i++) begin
      lvl0[i] = SampleMin;
    end
    for (int i = 0; i < WinDepth; i++) begin
      if (AgeW'(i) <= ctrl_i.amax) begin
        lvl0[i] = cand[i];
      end
    end
    for (int i = 0; i < TreeN/2; i++) begin
      lvl1[i] = smax(lvl0[2*i], lvl0[2*i+1]);
    end
    for (int i = 0; i < TreeN/4; i++) begin
      lvl2[i] = smax(lvl1[2*i], lvl1[2*i+1]);
    end
    for (int i = 0; i < TreeN/8; i++) begin
      lvl3[i] = smax(lvl2[2*i], lvl2[2*i+1]);
    end
    max_o = smax(lvl3[0], lvl3[1]);
  end

endmodule

/* hw/rtl/windowed_peak_smoother_top.sv */
// Top level of the windowed peak smoother: frame control, level memory and update.
//
// Takes one sample per cycle and gives one updated level per cycle while the output
// does not stall and no drain runs. Bin j is answered once the sample of bin j+r has
// arrived (r = min(precision, 10)/2); its level passes the issue and update registers
// into the output register. On the last sample of a frame the min(r, n) bins still
// waiting (at most five) drain from the window one per cycle while the output does
// not stall, and in_ready_o stays low until they are done. Levels live in a 512-entry
// memory with a registered read; a fill count stands in for its zero reset, so no
// clearing pass is run. frame_size and precision latch at each frame's first sample.
module windowed_peak_smoother_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wps_pkg::CfgDataW-1:0] cfg_data_i,
  // Sample items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  wps_pkg::sample_t             sample_i,
  // Level items
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output wps_pkg::sample_t             level_o,
  output logic [wps_pkg::BinW-1:0]     bin_index_o,
  output logic                         last_in_frame_o
);
  import wps_pkg::*;

  localparam int unsigned DW = SampleW + 3;

  // Configuration registers
  logic [FrameW-1:0] frame_size_q;
  logic [QW-1:0]     quantity_q;
  logic [PrecW-1:0]  precision_q;

  // Frame control
  logic [BinW-1:0] in_cnt_q, in_cnt_d;
  logic [CntW-1:0] out_cnt_q, out_cnt_d;
  logic [CntW-1:0] n_q, n_d;
  logic [RadW-1:0] r_q, r_d;
  logic            flush_q, flush_d;
  logic [CntW-1:0] fill_q;

  // Issue stage
  logic            a_valid_q;
  logic [BinW-1:0] a_bin_q;
  logic            a_last_q;
  logic            a_fresh_q;
  sample_t         a_max_q;
  sample_t         rd_data_q;

  // Update stage
  logic            e_valid_q;
  logic [BinW-1:0] e_bin_q;
  logic            e_last_q;
  sample_t         e_max_q;
  sample_t         e_lv_q;
  sample_t         e_new;

  // Output register
  logic            out_valid_q;
  sample_t         out_level_q;
  logic [BinW-1:0] out_bin_q;
  logic            out_last_q;

  sample_t lvl_mem [MaxBins];

  logic            adv;
  logic            accept;
  logic            first;
  logic [CntW-1:0] n_sat;
  logic [PrecW-1:0] p_sat;
  logic [CntW-1:0] n_eff, n_cur;
  logic [RadW-1:0] r_eff, r_cur;
  logic [CntW-1:0] nb, nb_next, jj, k_inc;
  logic            emit_reg, last_in, issue;
  logic [BinW-1:0] kk, dd;
  logic [AgeW-1:0] age_sum, amax;
  win_ctrl_t       win_ctrl;
  sample_t         win_max;
  sample_t         lv_fwd;

  logic [QW-1:0]          q_sat;
  logic signed [SampleW:0] diff;
  logic signed [2*SampleW+1:0] prod;
  logic signed [DW-1:0]   sum;

  // The whole pipeline moves unless a finished level is held
  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv && !flush_q;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q <= FrameSizeRst;
      quantity_q   <= QuantityRst;
      precision_q  <= PrecisionRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFrameSize: frame_size_q <= cfg_data_i[FrameW-1:0];
        CfgQuantity:  quantity_q   <= cfg_data_i[QW-1:0];
        CfgPrecision: precision_q  <= cfg_data_i[PrecW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the frame settings taken at the first sample
  always_comb begin
    if (frame_size_q == '0) begin
      n_sat = CntW'(1);
    end else if (CntW'(frame_size_q) > CntW'(MaxBins)) begin
      n_sat = CntW'(MaxBins);
    end else begin
      n_sat = CntW'(frame_size_q);
    end
    p_sat = (precision_q > PrecW'(MaxPrec)) ? PrecW'(MaxPrec) : precision_q;
  end

  // Frame control: which bin to answer now and how far the window reaches
  always_comb begin
    first   = (in_cnt_q == '0);
    n_eff   = first ? n_sat : n_q;
    r_eff   = first ? RadW'(p_sat >> 1) : r_q;
    nb      = first ? '0 : out_cnt_q;
    emit_reg = (in_cnt_q >= BinW'(r_eff));
    k_inc   = CntW'(in_cnt_q) + CntW'(1);
    last_in = (k_inc >= n_eff);
    nb_next = nb + CntW'(emit_reg);

    n_cur = flush_q ? n_q : n_eff;
    r_cur = flush_q ? r_q : r_eff;
    jj    = flush_q ? out_cnt_q : nb;
    kk    = flush_q ? BinW'(n_q - CntW'(1)) : in_cnt_q;
    issue = adv && (flush_q || (in_valid_i && emit_reg));

    // Ages that count: up to the earlier edge of the window, not before bin zero
    dd      = kk - jj[BinW-1:0];
    age_sum = AgeW'(dd) + AgeW'(r_cur);
    amax    = (kk < BinW'(age_sum)) ? AgeW'(kk) : age_sum;

    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    n_d       = n_q;
    r_d       = r_q;
    flush_d   = flush_q;
    if (flush_q) begin
      if (adv) begin
        out_cnt_d = out_cnt_q + CntW'(1);
        if (out_cnt_d >= n_q) begin
          flush_d   = 1'b0;
          out_cnt_d = '0;
        end
      end
    end else if (accept) begin
      n_d = n_eff;
      r_d = r_eff;
      if (last_in) begin
        in_cnt_d = '0;
        if (nb_next < n_eff) begin
          flush_d   = 1'b1;
          out_cnt_d = nb_next;
        end else begin
          out_cnt_d = '0;
        end
      end else begin
        in_cnt_d  = BinW'(k_inc);
        out_cnt_d = nb_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      n_q       <= CntW'(MaxBins);
      r_q       <= '0;
      flush_q   <= 1'b0;
    end else begin
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      n_q       <= n_d;
      r_q       <= r_d;
      flush_q   <= flush_d;
    end
  end

  assign win_ctrl.shift    = accept;
  assign win_ctrl.incl_new = !flush_q;
  assign win_ctrl.amax     = amax;

  wps_window u_window (
    .clk_i    (clk_i),
    .ctrl_i   (win_ctrl),
    .sample_i (sample_i),
    .max_o    (win_max)
  );

  // Level memory: registered read at issue, write back from the update stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_data_q <= lvl_mem[jj[BinW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && e_valid_q) begin
      lvl_mem[e_bin_q] <= e_new;
    end
  end

  // Count bins written so far; bins at or above it read as zero, as the memory has no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (adv && e_valid_q && (CntW'(e_bin_q) >= fill_q)) begin
      fill_q <= CntW'(e_bin_q) + CntW'(1);
    end
  end

  // Issue stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_bin_q   <= jj[BinW-1:0];
      a_last_q  <= (jj == n_cur - CntW'(1));
      a_fresh_q <= (jj >= fill_q);
      a_max_q   <= win_max;
    end
  end

  // Forward levels still on their way to memory
  always_comb begin
    if (e_valid_q && (e_bin_q == a_bin_q)) begin
      lv_fwd = e_new;
    end else if (out_valid_q && (out_bin_q == a_bin_q)) begin
      lv_fwd = out_level_q;
    end else if (a_fresh_q) begin
      lv_fwd = '0;
    end else begin
      lv_fwd = rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (adv) begin
      e_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_bin_q  <= a_bin_q;
      e_last_q <= a_last_q;
      e_max_q  <= a_max_q;
      e_lv_q   <= lv_fwd;
    end
  end

  // Move the level toward the window maximum, floored, clamped to range
  always_comb begin
    q_sat = (quantity_q > QOne) ? QOne : quantity_q;
    diff  = (SampleW+1)'(e_max_q) - (SampleW+1)'(e_lv_q);
    prod  = diff * $signed({1'b0, q_sat});
    sum   = DW'(e_lv_q) + $signed(prod[2*SampleW+1:QFrac]);
    if (sum > DW'(SampleMax)) begin
      e_new = SampleMax;
    end else if (sum < DW'(SampleMin)) begin
      e_new = SampleMin;
    end else begin
      e_new = SampleW'(sum);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_level_q <= e_new;
      out_bin_q   <= e_bin_q;
      out_last_q  <= e_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_o         = out_level_q;
  assign bin_index_o     = out_bin_q;
  assign last_in_frame_o = out_last_q;

endmodule

/* test/tb_windowed_peak_smoother_top.sv */
// Testbench of the windowed peak smoother: directed and random frames checked against a predictor.
module tb_windowed_peak_smoother_top;
  import wps_pkg::*;

  // No register sits behind this index; writes to it must change nothing
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 2'd3;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 16;

  typedef struct packed {
    sample_t          level;
    logic [BinW-1:0]  bin_index;
    logic             last_in_frame;
  } level_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  sample_t             sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sample_t             level_o;
  logic [BinW-1:0]     bin_index_o;
  logic                last_in_frame_o;

  // Predictor state: registers, per-bin levels and the samples of the current frame
  logic [FrameW-1:0] reg_frame_size = FrameSizeRst;
  logic [QW-1:0]     reg_quantity = QuantityRst;
  logic [PrecW-1:0]  reg_precision = PrecisionRst;
  sample_t           bin_levels [MaxBins];
  sample_t           frame_samples [MaxBins];
  int unsigned       bins_taken = 0;
  int unsigned       bins_answered = 0;
  int unsigned       frame_bins_latched = MaxBins;
  int unsigned       window_radius = 0;

  level_item_t       pending_levels [$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       ready_hold_cycles = 0;

  windowed_peak_smoother_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_o         (level_o),
    .bin_index_o     (bin_index_o),
    .last_in_frame_o (last_in_frame_o)
  );

  always #10 clk_i = ~clk_i;

  // Effective frame length for a frame_size register value
  function automatic int unsigned frame_bins(input logic [FrameW-1:0] size);
    if (size == 0) return 1;
    if (size > MaxBins) return MaxBins;
    return size;
  endfunction

  // Move the level of bin j toward the window peak and queue the expected item
  task automatic answer_bin(input int unsigned j);
    int unsigned lo, hi, t, weight;
    sample_t     peak;
    int          step_prod, next_level;
    level_item_t item;
    lo = (j >= window_radius) ? j - window_radius : 0;
    hi = (j + window_radius <= frame_bins_latched - 1) ? j + window_radius
                                                       : frame_bins_latched - 1;
    peak = frame_samples[lo];
    for (t = lo + 1; t <= hi; t++)
      if (frame_samples[t] > peak) peak = frame_samples[t];
    weight = (reg_quantity > QOne) ? QOne : reg_quantity;
    step_prod = (int'(peak) - int'(bin_levels[j])) * int'(weight);
    next_level = int'(bin_levels[j]) + (step_prod >>> QFrac);
    if (next_level > int'(SampleMax)) next_level = int'(SampleMax);
    if (next_level < int'(SampleMin)) next_level = int'(SampleMin);
    bin_levels[j] = sample_t'(next_level);
    item.level = sample_t'(next_level);
    item.bin_index = j[BinW-1:0];
    item.last_in_frame = (j == frame_bins_latched - 1);
    pending_levels.push_back(item);
  endtask

  // Take one sample into the predictor; frame length and radius latch on bin 0
  task automatic predict_levels(input sample_t s);
    int unsigned prec;
    if (bins_taken == 0) begin
      prec = (reg_precision > MaxPrec) ? MaxPrec : reg_precision;
      frame_bins_latched = frame_bins(reg_frame_size);
      window_radius = prec / 2;
      bins_answered = 0;
    end
    frame_samples[bins_taken] = s;
    if (bins_taken >= window_radius && bins_answered <= bins_taken - window_radius) begin
      answer_bin(bins_answered);
      bins_answered++;
    end
    if (bins_taken + 1 >= frame_bins_latched) begin
      // Flush the bins still waiting on lookahead
      while (bins_answered < frame_bins_latched) begin
        answer_bin(bins_answered);
        bins_answered++;
      end
      bins_taken = 0;
      bins_answered = 0;
    end else begin
      bins_taken++;
    end
  endtask

  // Follow every handshake at the rising edge: predict, check and watch for a hang
  always @(posedge clk_i) begin : monitor
    level_item_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgFrameSize: reg_frame_size = cfg_data_i[FrameW-1:0];
          CfgQuantity:  reg_quantity = cfg_data_i[QW-1:0];
          CfgPrecision: reg_precision = cfg_data_i[PrecW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) predict_levels(sample_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_levels.size() == 0) begin
          $error("level item with none pending: bin_index %0d level %0d",
                 bin_index_o, level_o);
          mismatch_count++;
        end else begin
          want = pending_levels.pop_front();
          if (level_o !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, level_o);
            mismatch_count++;
          end
          if (bin_index_o !== want.bin_index) begin
            $error("bin_index: expected %0d, got %0d", want.bin_index, bin_index_o);
            mismatch_count++;
          end
          if (last_in_frame_o !== want.last_in_frame) begin
            $error("last_in_frame: expected %0d, got %0d",
                   want.last_in_frame, last_in_frame_o);
            mismatch_count++;
          end
        end
      end
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("tb_windowed_peak_smoother_top: done, errors");
          $finish;
        end
      end
    end
  end

  // Receiver: hold off while a stretch is requested, else stall at random
  always @(negedge clk_i) begin
    if (ready_hold_cycles != 0) begin
      out_ready_i <= 1'b0;
      ready_hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one sample, idling first at random; leaves valid high after the item goes
  task automatic send_sample(input sample_t s);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait until every expected level has come, then let the pipe empty
  task automatic settle(input int unsigned extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return SampleMax;
      1: return SampleMin;
      2: return sample_t'(int'($urandom_range(0, 64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) send_sample(pick_sample());
  endtask

  // Random register set: mostly small frames, stray upper data bits included
  task automatic pick_config();
    logic [QW-1:0]     q;
    logic [FrameW-1:0] size;
    case ($urandom_range(0, 4))
      0: q = '0;
      1: q = QOne;
      2: q = '1;
      3: q = QW'($urandom_range(0, 32768));
      default: q = QW'($urandom);
    endcase
    size = ($urandom_range(0, 7) == 0) ? FrameW'($urandom_range(25, 80))
                                       : FrameW'($urandom_range(0, 20));
    write_reg(CfgFrameSize, {6'($urandom), size});
    write_reg(CfgQuantity, q);
    write_reg(CfgPrecision, {12'($urandom), 4'($urandom)});
    if ($urandom_range(0, 5) == 0) write_reg(CfgSpareIdx, 16'($urandom));
  endtask

  // Reset quantity and precision, short frame with stray upper bits in the size word
  task automatic test_reset_values();
    write_reg(CfgFrameSize, 16'hFC04);
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(sample_t'(0));
    send_sample(sample_t'(1));
    settle(DrainCycles);
  endtask

  // Field extremes, saturating registers, one-bin frames and floored negative steps
  task automatic test_extremes();
    write_reg(CfgQuantity, QOne);
    write_reg(CfgPrecision, 16'd10);
    write_reg(CfgFrameSize, 16'd8);
    send_sample(SampleMin);
    send_sample(SampleMax);
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(sample_t'(16'sh4000));
    settle(DrainCycles);
    write_reg(CfgQuantity, 16'hFFFF);
    write_reg(CfgPrecision, 16'hFFFF);
    write_reg(CfgFrameSize, 16'd0);
    write_reg(CfgSpareIdx, 16'hFFFF);
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(SampleMax);
    settle(DrainCycles);
    write_reg(CfgQuantity, 16'd0);
    write_reg(CfgPrecision, 16'd1);
    write_reg(CfgFrameSize, 16'd3);
    send_frame(3);
    settle(DrainCycles);
    write_reg(CfgQuantity, 16'd1);
    write_reg(CfgPrecision, 16'd3);
    write_reg(CfgFrameSize, 16'd2);
    send_sample(SampleMin);
    send_sample(SampleMin);
    settle(DrainCycles);
    write_reg(CfgQuantity, 16'h7FFF);
    write_reg(CfgPrecision, 16'd2);
    write_reg(CfgFrameSize, 16'd4);
    send_sample(SampleMin);
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(SampleMin);
    settle(DrainCycles);
  endtask

  // Size and precision hold for the running frame; quantity applies at once
  task automatic test_mid_frame_change();
    write_reg(CfgFrameSize, 16'd10);
    write_reg(CfgPrecision, 16'd4);
    write_reg(CfgQuantity, 16'd20000);
    send_frame(5);
    settle(DrainCycles);
    write_reg(CfgFrameSize, 16'd3);
    write_reg(CfgPrecision, 16'd0);
    write_reg(CfgQuantity, QOne);
    send_frame(5);
    send_frame(3);
    settle(DrainCycles);
  endtask

  // Long receiver hold-off with a busy sender, then a sender pause mid-frame
  task automatic test_backpressure();
    write_reg(CfgFrameSize, 16'd24);
    write_reg(CfgPrecision, 16'd10);
    write_reg(CfgQuantity, 16'd30000);
    @(negedge clk_i);
    ready_hold_cycles = 200;
    send_frame(24);
    send_frame(10);
    settle(0);
    send_frame(14);
    settle(DrainCycles);
  endtask

  // Random frames, back to back or with a new register set between them
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned items);
    int unsigned sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    pick_config();
    while (sent < items) begin
      if ($urandom_range(0, 1) == 0) begin
        settle(DrainCycles);
        pick_config();
      end
      send_frame(frame_bins(reg_frame_size));
      sent += frame_bins(reg_frame_size);
    end
    settle(DrainCycles);
  endtask

  initial begin
    int j;
    for (j = 0; j < MaxBins; j++) begin
      bin_levels[j] = '0;
      frame_samples[j] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_extremes();
    test_mid_frame_change();
    test_backpressure();
    test_random_traffic(0, 0, 20);
    test_random_traffic(49, 0, 20);
    test_random_traffic(0, 49, 20);
    test_random_traffic(28, 28, 20);

    settle(DrainCycles);
    if (mismatch_count == 0 && pending_levels.size() == 0) begin
      $display("tb_windowed_peak_smoother_top: done, clean");
    end else begin
      $display("tb_windowed_peak_smoother_top: done, errors");
    end
    $finish;
  end

endmodule
